@@ rtl/core/mtpa_pkg.sv @@
`timescale 1ns / 1ps
package mtpa_pkg;

  localparam int MAX_TESTS_DEF = 64;
  localparam int P_W           = 32;
  localparam int METH_W        = 2;
  localparam int DIV_STEP      = 8;

  localparam logic [P_W-1:0] ONE_Q31 = 32'h8000_0000;

  localparam logic [METH_W-1:0] METH_BONF  = 2'd0;
  localparam logic [METH_W-1:0] METH_HOLM  = 2'd1;
  localparam logic [METH_W-1:0] METH_BH    = 2'd2;
  localparam logic [METH_W-1:0] METH_RESET = METH_BH;

  // Per-cycle command for the whole row of sorting cells.
  typedef struct packed {
    logic ins;
    logic shl;
    logic shr;
  } cell_ctl_t;

endpackage

@@ rtl/core/mtpa_ifs.sv @@
`timescale 1ns / 1ps
interface mtpa_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] p_value;
  logic        last_item;
  modport source (output valid, p_value, last_item, input ready);
  modport sink   (input valid, p_value, last_item, output ready);
endinterface

interface mtpa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] adj_p;
  logic        last_result;
  logic        set_overflow;
  modport source (output valid, adj_p, last_result, set_overflow, input ready);
  modport sink   (input valid, adj_p, last_result, set_overflow, output ready);
endinterface

interface mtpa_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] method;
  modport source (output valid, method, input ready);
  modport sink   (input valid, method, output ready);
endinterface

@@ rtl/core/multiple_test_p_adjust_core.sv @@
`timescale 1ns / 1ps
// Loading accepts one request per cycle while the block is idle; the sorted insertion happens in the cell row at once.
// After the request marked last, Bonferroni and Holm take each item through S_MUL and S_ACC.
// Benjamini-Hochberg first rotates the row (S_ROT) by MAX_TESTS - n places, then takes each
// item through multiply, divider start, divider and write (S_MUL, S_DST, S_DIV, S_ACC).
// Results then leave through the registered RAM read; the next set loads after that.
// Reset (rst_n, synchronous, active low) clears counters, flags and state; method returns to 2.
module multiple_test_p_adjust_core import mtpa_pkg::*; #(
  parameter int MAX_TESTS = MAX_TESTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mtpa_in_if.sink     in_ch,
  mtpa_out_if.source  out_ch,
  mtpa_cfg_if.sink    cfg_ch
);

  localparam int IDX_W  = (MAX_TESTS > 1) ? $clog2(MAX_TESTS) : 1;
  localparam int CNT_W  = $clog2(MAX_TESTS + 1);
  localparam int PROD_W = P_W + CNT_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TESTS);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ROT  = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_DST  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_ACC  = 7'b0100000,
    S_RD   = 7'b1000000
  } state_t;

  // S_OUT is folded into S_RD via the rd_wait flag below.
  state_t state_r, state_nxt;

  logic [METH_W-1:0] meth_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              ovf_r;
  logic [CNT_W-1:0]  n_r;
  logic              set_ovf_r;
  logic              holm_r, bh_r;
  logic [CNT_W-1:0]  i_r;
  logic [CNT_W-1:0]  rot_r;
  logic [PROD_W-1:0] prod_r;
  logic [IDX_W-1:0]  org_r;
  logic [P_W-1:0]    run_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              rd_wait_r;

  logic              out_valid_r;
  logic [P_W-1:0]    out_adj_r;
  logic              out_last_r;
  logic              out_ovf_r;

  // Configuration is always accepted; the method is sampled when a set closes.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meth_r <= METH_RESET;
    end else if (cfg_ch.valid) begin
      meth_r <= cfg_ch.method;
    end
  end

  // ---------------------------------------------------------------------------
  // Sorting row. Each cell holds one entry of the ascending store; occupancy is
  // derived from the fill count. On insertion every cell compares itself with
  // the new value and entries above it move one place right. While adjusting,
  // the row shifts left (ascending pass, read at cell 0) or rotates right
  // (descending pass, read at the last cell).
  // ---------------------------------------------------------------------------
  logic                 in_acc;
  cell_ctl_t            ctl;
  logic [P_W-1:0]       cval [MAX_TESTS];
  logic [IDX_W-1:0]     corg [MAX_TESTS];
  logic [MAX_TESTS-1:0] cgt;
  logic [MAX_TESTS-1:0] occ;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign ctl.ins = in_acc && (cnt_r < MAX_CNT);
  assign ctl.shl = (state_r == S_ACC) && !bh_r;
  assign ctl.shr = (state_r == S_ROT) || ((state_r == S_ACC) && bh_r);

  for (genvar k = 0; k < MAX_TESTS; k++) begin : g_cell
    localparam int LK = (k == 0) ? MAX_TESTS - 1 : k - 1;
    localparam int RK = (k == MAX_TESTS - 1) ? 0 : k + 1;
    logic l_occ, l_gt;

    assign occ[k] = CNT_W'(k) < cnt_r;
    assign l_occ  = (k == 0) ? 1'b1 : occ[LK];
    assign l_gt   = (k == 0) ? 1'b0 : cgt[LK];

    mtpa_cell #(.IDX_W(IDX_W)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_val   (in_ch.p_value),
      .new_org   (cnt_r[IDX_W-1:0]),
      .occ       (occ[k]),
      .left_occ  (l_occ),
      .left_gt   (l_gt),
      .left_val  (cval[LK]),
      .left_org  (corg[LK]),
      .right_val (cval[RK]),
      .right_org (corg[RK]),
      .val_q     (cval[k]),
      .org_q     (corg[k]),
      .gt        (cgt[k])
    );
  end

  // Entry under the read head for the current pass.
  logic [P_W-1:0]   cur_val;
  logic [IDX_W-1:0] cur_org;
  assign cur_val = bh_r ? cval[MAX_TESTS-1] : cval[0];
  assign cur_org = bh_r ? corg[MAX_TESTS-1] : corg[0];

  // ---------------------------------------------------------------------------
  // Arithmetic. Holm scales by n - i for 0-based rank i, others by n. For Benjamini-Hochberg
  // the divisor is the 1-based rank, which is n - i on the descending pass. The
  // dividend is clamped to 2^31 * rank so that the quotient is already capped.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]  factor;
  logic [CNT_W-1:0]  rank;
  logic [PROD_W-1:0] lim;
  logic [PROD_W-1:0] div_num;
  logic              div_done;
  logic [P_W-1:0]    div_q;
  logic [P_W-1:0]    cap_prod;
  logic [P_W-1:0]    v;
  logic [P_W-1:0]    run_new;
  logic              first;

  assign rank    = n_r - i_r;
  assign factor  = holm_r ? rank : n_r;
  assign lim     = PROD_W'({rank, {(P_W-1){1'b0}}});
  assign div_num = (prod_r > lim) ? lim : prod_r;

  mtpa_div #(.NUM_W(PROD_W), .DEN_W(CNT_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DST),
    .num   (div_num),
    .den   (rank),
    .done  (div_done),
    .quo   (div_q)
  );

  assign cap_prod = (prod_r > PROD_W'(ONE_Q31)) ? ONE_Q31 : prod_r[P_W-1:0];
  assign v        = bh_r ? div_q : cap_prod;
  assign first    = (i_r == '0);

  // Capping is monotonic, so the running extremum works on capped values.
  always_comb begin
    run_new = v;
    if (holm_r) begin
      if (!first && !(v > run_r)) run_new = run_r;
    end else if (bh_r) begin
      if (!first && !(v < run_r)) run_new = run_r;
    end
  end

  // Results are scattered by arrival index and read back in order.
  logic [P_W-1:0] ram_rdata;

  mtpa_ram #(.WIDTH(P_W), .DEPTH(MAX_TESTS)) u_ram (
    .clk   (clk),
    .we    (state_r == S_ACC),
    .waddr (org_r),
    .wdata (run_new),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] n_new;
  logic             new_bh;
  logic             out_free;
  logic             rd_last;

  assign n_new    = (cnt_r < MAX_CNT) ? cnt_r + 1'b1 : cnt_r;
  assign new_bh   = (meth_r != METH_BONF) && (meth_r != METH_HOLM);
  assign out_free = !out_valid_r || out_ch.ready;
  assign rd_last  = ({1'b0, rd_idx_r} == CNT_W'(n_r - 1'b1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.last_item) begin
          state_nxt = (new_bh && (n_new != MAX_CNT)) ? S_ROT : S_MUL;
        end
      end
      S_ROT: begin
        if (rot_r == CNT_W'(1)) state_nxt = S_MUL;
      end
      S_MUL: state_nxt = bh_r ? S_DST : S_ACC;
      S_DST: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) state_nxt = S_ACC;
      end
      S_ACC: state_nxt = (i_r == n_r - 1'b1) ? S_RD : S_MUL;
      S_RD: begin
        if (rd_wait_r && out_free && rd_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      rd_wait_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == S_IDLE && in_acc) begin
        if (in_ch.last_item) begin
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end else begin
          cnt_r <= n_new;
          ovf_r <= ovf_r || (cnt_r == MAX_CNT);
        end
      end

      // The read address goes out first; data is taken from the registered read once rd_wait is set.
      if (state_r == S_RD) begin
        if (!rd_wait_r) begin
          rd_wait_r <= 1'b1;
        end else if (out_free) begin
          rd_wait_r <= 1'b0;
        end
      end

      if (state_r == S_RD && rd_wait_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.last_item) begin
          n_r       <= n_new;
          set_ovf_r <= ovf_r || (cnt_r == MAX_CNT);
          holm_r    <= (meth_r == METH_HOLM);
          bh_r      <= new_bh;
          i_r       <= '0;
          rot_r     <= MAX_CNT - n_new;
          rd_idx_r  <= '0;
        end
      end
      S_ROT: rot_r <= rot_r - 1'b1;
      S_MUL: begin
        prod_r <= PROD_W'(cur_val) * PROD_W'(factor);
        org_r  <= cur_org;
      end
      S_ACC: begin
        run_r <= run_new;
        i_r   <= i_r + 1'b1;
      end
      S_RD: begin
        if (rd_wait_r && out_free) begin
          out_adj_r  <= ram_rdata;
          out_last_r <= rd_last;
          out_ovf_r  <= set_ovf_r;
          rd_idx_r   <= rd_idx_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.adj_p        = out_adj_r;
  assign out_ch.last_result  = out_last_r;
  assign out_ch.set_overflow = out_ovf_r;

endmodule

@@ rtl/core/mtpa_ram.sv @@
`timescale 1ns / 1ps
module mtpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/mtpa_cell.sv @@
`timescale 1ns / 1ps
module mtpa_cell import mtpa_pkg::*; #(
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [P_W-1:0]   new_val,
  input  logic [IDX_W-1:0] new_org,
  input  logic             occ,
  input  logic             left_occ,
  input  logic             left_gt,
  input  logic [P_W-1:0]   left_val,
  input  logic [IDX_W-1:0] left_org,
  input  logic [P_W-1:0]   right_val,
  input  logic [IDX_W-1:0] right_org,
  output logic [P_W-1:0]   val_q,
  output logic [IDX_W-1:0] org_q,
  output logic             gt
);

  logic [P_W-1:0]   val_r, val_nxt;
  logic [IDX_W-1:0] org_r, org_nxt;

  // Greater-than flag goes to the right neighbor; equal values stay put so
  // that ties keep arrival order.
  assign gt = occ && (val_r > new_val);

  always_comb begin
    val_nxt = val_r;
    org_nxt = org_r;
    priority if (ctl.ins) begin
      if (left_gt) begin
        val_nxt = left_val;
        org_nxt = left_org;
      end else if (gt || (!occ && left_occ)) begin
        val_nxt = new_val;
        org_nxt = new_org;
      end
    end else if (ctl.shl) begin
      val_nxt = right_val;
      org_nxt = right_org;
    end else if (ctl.shr) begin
      val_nxt = left_val;
      org_nxt = left_org;
    end else begin
      val_nxt = val_r;
      org_nxt = org_r;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    org_r <= org_nxt;
  end

  assign val_q = val_r;
  assign org_q = org_r;

endmodule

@@ rtl/core/mtpa_div.sv @@
`timescale 1ns / 1ps
module mtpa_div import mtpa_pkg::*; #(
  parameter int NUM_W = 39,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [P_W-1:0]   quo
);

  localparam int ITERS  = (NUM_W + DIV_STEP - 1) / DIV_STEP;
  localparam int WORK_W = ITERS * DIV_STEP;
  localparam int IT_W   = $clog2(ITERS + 1);

  logic [WORK_W-1:0] work_r, work_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [IT_W-1:0]   it_r;
  logic              busy_r;
  logic              done_r;

  // Restoring long division, a byte of quotient bits per cycle while busy.
  always_comb begin
    logic [DEN_W:0]    t;
    logic [DEN_W-1:0]  r;
    logic [WORK_W-1:0] w;
    r = rem_r;
    w = work_r;
    for (int s = 0; s < DIV_STEP; s++) begin
      t = {r, w[WORK_W-1]};
      w = {w[WORK_W-2:0], 1'b0};
      if (t >= {1'b0, den_r}) begin
        t    = t - {1'b0, den_r};
        w[0] = 1'b1;
      end
      r = t[DEN_W-1:0];
    end
    work_nxt = w;
    rem_nxt  = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        it_r   <= IT_W'(ITERS);
      end else if (busy_r) begin
        it_r <= it_r - 1'b1;
        if (it_r == IT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= WORK_W'(num);
      rem_r  <= '0;
      den_r  <= den;
    end else if (busy_r) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = work_r[P_W-1:0];

endmodule

@@ tb/tb_multiple_test_p_adjust_core.sv @@
`timescale 1ns / 1ps
module tb_multiple_test_p_adjust_core;
  import mtpa_pkg::*;

  localparam int NTESTS = MAX_TESTS_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD = 2000;

  // The spare method code, which behaves like Benjamini-Hochberg.
  localparam logic [METH_W-1:0] METH_SPARE = 2'd3;

  // One queued expectation per result the block owes us.
  typedef struct {
    logic [31:0] adj;
    logic        last;
    logic        ovf;
  } adj_result_t;

  // One row of the directed stimulus. Where has_exp is set, the row ends a
  // one-item set and its single result can be read off directly.
  typedef struct {
    logic [31:0] p;
    logic        last;
    bit          has_exp;
    logic [31:0] exp_adj;
  } stim_row_t;

  logic clk;
  logic rst_n;

  mtpa_in_if  in_ch ();
  mtpa_out_if out_ch ();
  mtpa_cfg_if cfg_ch ();

  multiple_test_p_adjust_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // Predictor state: the set loaded so far, in arrival order, and the method.
  logic [31:0]     set_vals[$];
  bit              set_dropped;
  logic [1:0]      cur_method;
  adj_result_t     pending_adj[$];
  int              mismatches;
  int              idle_cycles;
  bit              timed_out;
  bit              hold_long;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Computes the adjusted set for the current method and queues the results
  // in arrival order. Ties in the sort keep arrival order.
  task automatic predict_set();
    int          n;
    int          ord[$];
    int          j;
    int          tmp;
    logic [63:0] v;
    logic [63:0] run;
    logic [31:0] adj[NTESTS];
    adj_result_t r;
    n = set_vals.size();
    ord = {};
    for (int i = 0; i < n; i++) ord.push_back(i);
    for (int i = 1; i < n; i++) begin
      j = i;
      while (j > 0 && set_vals[ord[j-1]] > set_vals[ord[j]]) begin
        tmp = ord[j]; ord[j] = ord[j-1]; ord[j-1] = tmp;
        j--;
      end
    end
    run = '0;
    if (cur_method == METH_BONF) begin
      for (int i = 0; i < n; i++) begin
        v = 64'(set_vals[ord[i]]) * 64'(n);
        adj[ord[i]] = (v > 64'(ONE_Q31)) ? ONE_Q31 : v[31:0];
      end
    end else if (cur_method == METH_HOLM) begin
      for (int i = 0; i < n; i++) begin
        v = 64'(set_vals[ord[i]]) * 64'(n - i);
        if (i == 0 || v > run) run = v;
        adj[ord[i]] = (run > 64'(ONE_Q31)) ? ONE_Q31 : run[31:0];
      end
    end else begin
      // Benjamini-Hochberg; the unused code behaves the same way.
      for (int i = n; i > 0; i--) begin
        v = (64'(set_vals[ord[i-1]]) * 64'(n)) / 64'(i);
        if (i == n || v < run) run = v;
        adj[ord[i-1]] = (run > 64'(ONE_Q31)) ? ONE_Q31 : run[31:0];
      end
    end
    for (int i = 0; i < n; i++) begin
      r.adj  = adj[i];
      r.last = (i == n - 1);
      r.ovf  = set_dropped;
      pending_adj.push_back(r);
    end
    set_vals = {};
    set_dropped = 1'b0;
  endtask

  // Feeds one accepted request to the predictor.
  task automatic absorb_request(input logic [31:0] p, input logic last);
    if (set_vals.size() < NTESTS) set_vals.push_back(p);
    else set_dropped = 1'b1;
    if (last) predict_set();
  endtask

  // Offers one request after a random gap and waits until it is accepted.
  // Valid stays high afterwards; a later call with a gap, or the drain, drops it.
  task automatic send_request(input logic [31:0] p, input logic last);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.p_value   <= p;
    in_ch.last_item <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    absorb_request(p, last);
    @(negedge clk);
  endtask

  // Waits until every result has come out, then lets the block settle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_adj.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Writes the method register while the block is idle.
  task automatic write_method(input logic [1:0] m);
    cfg_ch.valid  <= 1'b1;
    cfg_ch.method <= m;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cur_method = m;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random p-value, mostly small, sometimes at the edges or above 1.0.
  function automatic logic [31:0] rand_p();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return ONE_Q31;
      2:       return $urandom();
      3:       return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 32'h0400_0000);
    endcase
  endfunction

  // Sends one set of n requests, the last one marked; past the capacity
  // the extra requests are dropped by the block.
  task automatic send_set(input int n);
    logic [31:0] p;
    for (int i = 0; i < n; i++) begin
      p = rand_p();
      send_request(p, i == n - 1);
    end
  endtask

  // Receiver: random backpressure, plus one long hold-off when asked.
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        for (int c = 0; c < LONG_HOLD; c++) @(negedge clk);
        hold_long = 1'b0;
      end
      if ($urandom_range(0, 2) == 0) begin
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        out_ch.ready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    adj_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_adj.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: adj_p=%h last=%b ovf=%b", out_ch.adj_p,
                   out_ch.last_result, out_ch.set_overflow);
      end else begin
        e = pending_adj.pop_front();
        if (out_ch.adj_p !== e.adj || out_ch.last_result !== e.last ||
            out_ch.set_overflow !== e.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected adj=%h last=%b ovf=%b, got adj=%h last=%b ovf=%b",
                     e.adj, e.last, e.ovf, out_ch.adj_p, out_ch.last_result,
                     out_ch.set_overflow);
        end
      end
    end
  end

  // Watchdog: counts cycles in which no request, result or write is accepted.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Directed stimulus table. Single-item sets have an obvious answer for
  // every method: p * 1, capped at 1.0.
  stim_row_t dir_rows[] = '{
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'h8000_0000},
    '{32'h0000_0001, 1'b1, 1'b1, 32'h0000_0001},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
    // A small set with ties and a value above 1.0, checked by the predictor.
    '{32'h0100_0000, 1'b0, 1'b0, 32'h0},
    '{32'h0080_0000, 1'b0, 1'b0, 32'h0},
    '{32'h0100_0000, 1'b0, 1'b0, 32'h0},
    '{32'hC000_0000, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b1, 1'b0, 32'h0}
  };

  initial begin
    int          m;
    adj_result_t e;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.p_value = '0;
    in_ch.last_item = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.method = '0;
    set_dropped = 1'b0;
    cur_method = METH_RESET;
    mismatches = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    hold_long = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under every method, starting from the reset method.
    for (int pass = 0; pass < 4; pass++) begin
      if (pass > 0) write_method(pass == 1 ? METH_BONF : (pass == 2 ? METH_HOLM : METH_SPARE));
      foreach (dir_rows[r]) begin
        send_request(dir_rows[r].p, dir_rows[r].last);
        if (dir_rows[r].has_exp) begin
          // The one result of this set is checked against the typed value.
          e = pending_adj.pop_back();
          e.adj = dir_rows[r].exp_adj;
          pending_adj.push_back(e);
        end
      end
      drain_results();
    end

    // Capacity overflow: one set with an item past the capacity, the last one
    // dropped but still ending the set. The receiver holds off meanwhile so
    // the block fills up and stalls its input.
    write_method(METH_BH);
    hold_long = 1'b1;
    send_set(NTESTS + 1);
    send_set(2);
    drain_results();

    // Random part: short sets with random method changes between phases.
    for (int ph = 0; ph < 4; ph++) begin
      m = $urandom_range(0, 3);
      write_method(m[1:0]);
      for (int s = 0; s < 2; s++) begin
        send_set($urandom_range(1, 5));
      end
      drain_results();
    end

    if (mismatches == 0 && pending_adj.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
